FILE: design/cbeq_pkg.sv
package cbeq_pkg;

  // defaults for the top-level parameters
  localparam int PEAK_BANDS_DEF  = 4;
  localparam int CHANNELS_DEF    = 2;
  localparam int SAMPLE_BITS_DEF = 24;

  // fixed field widths
  localparam int IO_BITS   = 24;
  localparam int COEF_BITS = 24;
  localparam int IDX_BITS  = 5;
  localparam int MASK_BITS = 4;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 4;

  // Q3.20 coefficients, five taps per stage
  localparam int FRAC_BITS = 20;
  localparam int TAPS      = 5;
  localparam int TAP_BITS  = 3;

  localparam logic [TAP_BITS-1:0] TAP_B0 = 3'd0;
  localparam logic [TAP_BITS-1:0] TAP_B1 = 3'd1;
  localparam logic [TAP_BITS-1:0] TAP_B2 = 3'd2;
  localparam logic [TAP_BITS-1:0] TAP_A1 = 3'd3;
  localparam logic [TAP_BITS-1:0] TAP_A2 = 3'd4;

  localparam logic [CFG_IDX_BITS-1:0] CFG_HIGHPASS  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOWPASS   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BAND_MASK = 2'd2;

  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_COEF   = 1'b1;

  typedef struct packed {
    logic                        action;
    logic                        channel;
    logic signed [IO_BITS-1:0]   sample_in;
    logic [IDX_BITS-1:0]         coef_index;
    logic signed [COEF_BITS-1:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic                      channel_out;
    logic signed [IO_BITS-1:0] sample_out;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MAC,
    ST_LAST,
    ST_WB
  } state_t;

endpackage

FILE: design/cascaded_biquad_equalizer_core.sv
// Stereo parametric equalizer: high-pass, PEAK_BANDS peaking bands and low-pass, each a
// direct form I biquad with Q3.20 coefficients, rounded half up and saturated per stage.
// Send coefficient writes (action=1, index = stage*5 + tap, taps b0 b1 b2 a1 a2) before
// enabling stages; a coefficient write returns nothing. A sample occupies the core while
// it runs the enabled stages in turn and steps past the bypassed ones; in_ready is low
// meanwhile. The single 24 x SAMPLE_BITS multiplier runs the five taps of each enabled
// stage one per cycle, after the history read and before the final add and write-back.
// The result sits in an output register, so the next item is taken while it waits.
// Samples on channels at CHANNELS or above are dropped.
module cascaded_biquad_equalizer_core import cbeq_pkg::*; #(
  parameter int PEAK_BANDS  = PEAK_BANDS_DEF,
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_data,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int STAGES     = PEAK_BANDS + 2;
  localparam int COEF_COUNT = STAGES * TAPS;
  localparam int HROWS      = CHANNELS * STAGES;
  localparam int CA_W       = $clog2(COEF_COUNT);
  localparam int CB_W       = $clog2(COEF_COUNT + 1);
  localparam int HI_W       = $clog2(HROWS);
  localparam int HR_W       = $clog2(HROWS + 1);
  localparam int SI_W       = $clog2(STAGES);
  localparam int ST_W       = $clog2(STAGES + 1);
  localparam int SB         = SAMPLE_BITS;
  localparam int XW         = (SAMPLE_BITS > IO_BITS) ? SAMPLE_BITS : IO_BITS;
  localparam int PW         = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_W      = PW + 3;

  localparam logic signed [XW-1:0]    SMAX_X = XW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [XW-1:0]    SMIN_X = -SMAX_X - XW'(1);
  localparam logic signed [ACC_W-1:0] SMAX_A =
    ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SMIN_A = -SMAX_A - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));

  typedef struct packed {
    logic signed [SB-1:0] x1;
    logic signed [SB-1:0] x2;
    logic signed [SB-1:0] y1;
    logic signed [SB-1:0] y2;
  } hrow_t;

  typedef struct packed {
    logic start;
    logic coef_we;
    logic coef_re;
    logic hist_re;
    logic hist_we;
    logic step;
    logic mac;
    logic load_out;
  } ctrl_t;

  state_t state, state_next;
  ctrl_t  ctl;

  // configuration
  logic                 hp_en;
  logic                 lp_en;
  logic [MASK_BITS-1:0] band_mask;
  logic [STAGES-1:0]    en_vec;

  // sequencer registers
  logic [ST_W-1:0]     st;
  logic [CB_W-1:0]     cbase;
  logic [HR_W-1:0]     hrow;
  logic [TAP_BITS-1:0] tap;
  logic                ch;
  logic signed [SB-1:0] xcur;

  // stores
  logic signed [COEF_BITS-1:0] coef_mem [COEF_COUNT];
  logic signed [COEF_BITS-1:0] coef_rd;
  logic [CB_W-1:0]             coef_raddr;
  hrow_t                       hist_mem [HROWS];
  logic [HROWS-1:0]            hist_vld;
  hrow_t                       hist_rd;
  logic                        hist_ok;
  hrow_t                       hist_eff;

  // datapath
  logic signed [SB-1:0]    op;
  logic signed [PW-1:0]    prod;
  logic                    prod_sub;
  logic                    prod_vld;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [ACC_W-1:0] acc_shr;
  logic signed [SB-1:0]    y;
  logic signed [XW-1:0]    x_ext;
  logic signed [SB-1:0]    x_sat;

  logic accept;
  logic is_coef;
  logic idx_ok;
  logic chan_ok;
  logic st_done;
  logic st_en;
  logic out_free;

  assign accept   = in_valid && in_ready;
  assign is_coef  = (in_data.action == ACT_COEF);
  assign idx_ok   = (32'(in_data.coef_index) < COEF_COUNT);
  assign chan_ok  = (32'(in_data.channel) < CHANNELS);
  assign st_done  = (32'(st) >= STAGES);
  assign st_en    = !st_done && en_vec[st[SI_W-1:0]];
  assign out_free = !out_valid || out_ready;

  // stage enables: high-pass first, bands, low-pass last; mask bits past the bands unused
  always_comb begin
    for (int s = 0; s < STAGES; s++) begin
      if (s == 0) begin
        en_vec[s] = hp_en;
      end else if (s == STAGES - 1) begin
        en_vec[s] = lp_en;
      end else if (s - 1 < MASK_BITS) begin
        en_vec[s] = band_mask[(s - 1) % MASK_BITS];
      end else begin
        en_vec[s] = 1'b0;
      end
    end
  end

  // input sample saturated to the internal sample width
  always_comb begin
    x_ext = XW'(in_data.sample_in);
    if (x_ext > SMAX_X) begin
      x_sat = SB'(SMAX_X);
    end else if (x_ext < SMIN_X) begin
      x_sat = SB'(SMIN_X);
    end else begin
      x_sat = SB'(x_ext);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && !is_coef && chan_ok) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (st_done) begin
          if (out_free) begin
            state_next = ST_IDLE;
          end
        end else if (st_en) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (tap == TAP_A2) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: state_next = ST_WB;
      ST_WB:   state_next = ST_SCAN;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.coef_we = accept && is_coef && idx_ok;
        ctl.start   = accept && !is_coef && chan_ok;
      end
      ST_SCAN: begin
        if (st_done) begin
          ctl.load_out = out_free;
        end else if (st_en) begin
          ctl.coef_re = 1'b1;
          ctl.hist_re = 1'b1;
        end else begin
          ctl.step = 1'b1;
        end
      end
      ST_MAC: begin
        ctl.mac     = 1'b1;
        ctl.coef_re = (tap != TAP_A2);
      end
      ST_WB: begin
        ctl.hist_we = 1'b1;
        ctl.step    = 1'b1;
      end
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hp_en     <= 1'b0;
      lp_en     <= 1'b0;
      band_mask <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_HIGHPASS:  hp_en     <= cfg_data[0];
        CFG_LOWPASS:   lp_en     <= cfg_data[0];
        CFG_BAND_MASK: band_mask <= cfg_data[MASK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // coefficient store: one write port, one registered read port
  always_comb begin
    if (state == ST_MAC) begin
      coef_raddr = CB_W'(cbase + CB_W'(tap) + CB_W'(1));
    end else begin
      coef_raddr = cbase;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.coef_we) begin
      coef_mem[CA_W'(in_data.coef_index)] <= in_data.coef_value;
    end
    if (ctl.coef_re) begin
      coef_rd <= coef_mem[coef_raddr[CA_W-1:0]];
    end
  end

  // history rows {x1,x2,y1,y2} per channel and stage; a row never written reads as zero
  assign hist_eff = hist_ok ? hist_rd : '0;

  always_comb begin
    case (tap)
      TAP_B0:  op = xcur;
      TAP_B1:  op = hist_eff.x1;
      TAP_B2:  op = hist_eff.x2;
      TAP_A1:  op = hist_eff.y1;
      TAP_A2:  op = hist_eff.y2;
      default: op = '0;
    endcase
  end

  always_comb begin
    acc_rnd = acc + RND_HALF;
    acc_shr = acc_rnd >>> FRAC_BITS;
    if (acc_shr > SMAX_A) begin
      y = SB'(SMAX_A);
    end else if (acc_shr < SMIN_A) begin
      y = SB'(SMIN_A);
    end else begin
      y = SB'(acc_shr);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.hist_re) begin
      hist_rd <= hist_mem[hrow[HI_W-1:0]];
    end
    if (ctl.hist_we) begin
      hist_mem[hrow[HI_W-1:0]] <= '{x1: xcur, x2: hist_eff.x1, y1: y, y2: hist_eff.y1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_vld <= '0;
    end else if (ctl.hist_we) begin
      hist_vld[hrow[HI_W-1:0]] <= 1'b1;
    end
  end

  // sequencer and multiply-accumulate
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      st    <= '0;
      cbase <= '0;
      hrow  <= in_data.channel ? HR_W'(STAGES) : '0;
      ch    <= in_data.channel;
      xcur  <= x_sat;
    end
    if (ctl.hist_re) begin
      hist_ok <= hist_vld[hrow[HI_W-1:0]];
      tap     <= TAP_B0;
      acc     <= '0;
    end
    if (ctl.step) begin
      st    <= ST_W'(st + ST_W'(1));
      cbase <= CB_W'(cbase + CB_W'(TAPS));
      hrow  <= HR_W'(hrow + HR_W'(1));
    end
    if (ctl.hist_we) begin
      xcur <= y;
    end
    if (ctl.mac) begin
      prod     <= coef_rd * op;
      prod_sub <= (tap == TAP_A1) || (tap == TAP_A2);
      if (tap != TAP_A2) begin
        tap <= TAP_BITS'(tap + TAP_BITS'(1));
      end
    end
    if (prod_vld) begin
      if (prod_sub) begin
        acc <= acc - ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctl.mac;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_data.channel_out <= ch;
      out_data.sample_out  <= IO_BITS'(XW'(xcur));
    end
  end

endmodule

FILE: design/cbeq_checker.sv
module cbeq_checker import cbeq_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // held result stays put until transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped before transfer");

  // reset leaves the core empty and open for input
  a_reset: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("core not idle after reset");

  // the core drops in_ready after accepting a filtered sample on a valid channel
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.action == ACT_FILTER
      && (CHANNELS > 1 || !in_data.channel) |=> !in_ready)
    else $error("core took input right after a sample transfer");

  // a coefficient write leaves the core ready for input
  a_coef_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.action == ACT_COEF |=> in_ready)
    else $error("core busy after a coefficient write");

endmodule

bind cascaded_biquad_equalizer_core cbeq_checker #(.CHANNELS(CHANNELS)) u_cbeq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
